>>> src/tca_pkg.sv
// package for the trade candle aggregator: payload structs, constants
// no dependencies
package tca_pkg;

    localparam int unsigned MaxFill = 62;
    localparam logic [26:0] TfReset = 27'd60000;

    typedef struct packed {
        logic [31:0] price;
        logic [39:0] volume;
        logic        is_buy;
        logic [47:0] timestamp_ms;
    } t_trade;

    typedef struct packed {
        logic [47:0] start_ms;
        logic [31:0] open_price;
        logic [31:0] high_price;
        logic [31:0] low_price;
        logic [31:0] close_price;
        logic [47:0] buy_volume;
        logic [47:0] sell_volume;
        logic [31:0] trade_count;
        logic        is_gap_fill;
        logic        gap_truncated;
        logic        last_of_run;
    } t_candle;

    // classified trade passed from front to back
    typedef struct packed {
        logic [31:0] price;
        logic [39:0] volume;
        logic        is_buy;
        logic [47:0] bucket;
    } t_job;

endpackage

>>> src/tca_front.sv
// front part: serial divide of timestamp by timeframe, one quotient bit a cycle
// depends on tca_pkg
module tca_front import tca_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [26:0] i_tf,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_trade      i_trade,
    output logic        o_valid,
    input  logic        i_ready,
    output t_job        o_job
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} t_state;

    t_state      r_state;
    logic [5:0]  r_cnt;
    logic [47:0] r_quo;
    logic [27:0] r_rem;
    logic [26:0] r_div;
    t_trade      r_trade;
    logic [27:0] n_sh;
    logic [28:0] n_diff;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_job   = '{price: r_trade.price, volume: r_trade.volume,
                       is_buy: r_trade.is_buy, bucket: r_quo};

    // restoring division step
    always_comb begin
        n_sh   = {r_rem[26:0], r_quo[47]};
        n_diff = {1'b0, n_sh} - {2'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_trade <= i_trade;
                    r_quo   <= i_trade.timestamp_ms;
                    r_rem   <= '0;
                    r_div   <= (i_tf == '0) ? 27'd1 : i_tf;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (n_diff[28]) begin
                        r_rem <= n_sh;
                        r_quo <= {r_quo[46:0], 1'b0};
                    end else begin
                        r_rem <= n_diff[27:0];
                        r_quo <= {r_quo[46:0], 1'b1};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) r_state <= S_DONE;
                end
                S_DONE: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/tca_queue.sv
// two-entry queue between front and back
// depends on tca_pkg
module tca_queue import tca_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);
    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_push;
    logic       n_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign n_push  = i_valid && o_ready;
    assign n_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (n_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (n_push) r_wp <= ~r_wp;
            if (n_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, n_push} - {1'b0, n_pop};
        end
    end
endmodule

>>> src/tca_back.sv
// back part: candle state, finished candle and gap candle emission
// depends on tca_pkg
module tca_back import tca_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [26:0] i_tf,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  logic        i_ready,
    output t_candle     o_candle
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_EMIT, S_GAP, S_OPEN} t_state;

    t_state      r_state;
    logic        r_started;
    logic [47:0] r_bucket;
    logic [31:0] r_open, r_high, r_low, r_close;
    logic [47:0] r_buy, r_sell;
    logic [31:0] r_count;
    t_job        r_job;
    logic [47:0] r_gidx;      // bucket of candle being emitted
    logic [5:0]  r_left;      // gap candles still to emit
    logic        r_trunc;
    logic [47:0] r_plo;       // low half of bucket times timeframe
    logic [23:0] r_phi;       // high half partial product, low 24 bits
    logic        r_gap;
    logic        r_ovalid;
    t_candle     r_out;

    logic [26:0] n_tf;
    logic [47:0] n_diff;
    logic [47:0] n_gaps;
    logic [47:0] n_add;
    logic [50:0] n_plo;
    logic [50:0] n_phi;

    // saturate a 49-bit sum to 48 bits
    function automatic logic [47:0] sat48(input logic [48:0] s);
        sat48 = s[48] ? '1 : s[47:0];
    endfunction

    assign n_tf   = (i_tf == '0) ? 27'd1 : i_tf;
    assign n_diff = r_job.bucket - r_bucket;
    assign n_gaps = n_diff - 48'd1;
    assign n_add  = {8'd0, r_job.volume};

    // start time product split into two 24 by 27 bit halves
    assign n_plo  = {27'd0, r_gidx[23:0]} * {24'd0, n_tf};
    assign n_phi  = {27'd0, r_gidx[47:24]} * {24'd0, n_tf};

    assign o_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_candle = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
            r_bucket  <= '0;
            r_open    <= '0;
            r_high    <= '0;
            r_low     <= '0;
            r_close   <= '0;
            r_buy     <= '0;
            r_sell    <= '0;
            r_count   <= '0;
        end else begin
            if (r_ovalid && i_ready && (r_state != S_EMIT)) r_ovalid <= 1'b0;
            unique case (r_state)
                // take a job: update in place, start emission, or open the first candle
                S_IDLE: if (i_valid && !r_ovalid) begin
                    r_job <= i_job;
                    if (r_started && i_job.bucket == r_bucket) begin
                        if (i_job.price > r_high) r_high <= i_job.price;
                        if (i_job.price < r_low)  r_low  <= i_job.price;
                        r_close <= i_job.price;
                        if (i_job.is_buy) begin
                            r_buy <= sat48({1'b0, r_buy} + {9'd0, i_job.volume});
                        end else begin
                            r_sell <= sat48({1'b0, r_sell} + {9'd0, i_job.volume});
                        end
                        if (r_count != '1) r_count <= r_count + 32'd1;
                    end else if (r_started) begin
                        r_gidx  <= r_bucket;
                        r_gap   <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_OPEN;
                    end
                end
                // gap count set up with the first multiply
                S_MUL: begin
                    r_plo <= n_plo[47:0];
                    r_phi <= n_phi[23:0];
                    if (!r_gap) begin
                        if (r_job.bucket > r_bucket) begin
                            r_left  <= (n_gaps > 48'(MaxFill)) ? 6'(MaxFill)
                                                               : n_gaps[5:0];
                            r_trunc <= (n_gaps > 48'(MaxFill));
                        end else begin
                            r_left  <= '0;
                            r_trunc <= 1'b0;
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: if (!r_ovalid || i_ready) begin
                    r_ovalid             <= 1'b1;
                    r_out.start_ms       <= r_plo + {r_phi, 24'd0};
                    r_out.open_price     <= r_gap ? r_close : r_open;
                    r_out.high_price     <= r_gap ? r_close : r_high;
                    r_out.low_price      <= r_gap ? r_close : r_low;
                    r_out.close_price    <= r_close;
                    r_out.buy_volume     <= r_gap ? '0 : r_buy;
                    r_out.sell_volume    <= r_gap ? '0 : r_sell;
                    r_out.trade_count    <= r_gap ? '0 : r_count;
                    r_out.is_gap_fill    <= r_gap;
                    r_out.gap_truncated  <= (r_left == '0) && r_trunc;
                    r_out.last_of_run    <= (r_left == '0);
                    if (r_left == '0) begin
                        r_state <= S_OPEN;
                    end else begin
                        r_left  <= r_left - 6'd1;
                        r_gidx  <= r_gidx + 48'd1;
                        r_gap   <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                // open new candle with this trade
                S_OPEN: begin
                    r_started <= 1'b1;
                    r_bucket  <= r_job.bucket;
                    r_open    <= r_job.price;
                    r_high    <= r_job.price;
                    r_low     <= r_job.price;
                    r_close   <= r_job.price;
                    r_buy     <= r_job.is_buy ? n_add : '0;
                    r_sell    <= r_job.is_buy ? '0 : n_add;
                    r_count   <= 32'd1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/trade_candle_aggregator_core.sv
// trade candle aggregator top level: front divider, queue, candle back end
// depends on tca_pkg, tca_front, tca_queue, tca_back
//
// usage: trades enter on i_valid/o_ready as one t_trade word; finished and
// gap-fill candles leave on o_valid/i_ready as t_candle words. a trade in
// the open candle's bucket only updates state and emits nothing; one in a
// new bucket emits the finished candle, up to 62 gap candles, and opens a
// new candle. the last word of a run has last_of_run set.
// timing: the front divides the 48-bit timestamp by the timeframe, one
// quotient bit a cycle, and takes no new trade until its result is passed
// on. the back end handles each emitted candle in two steps (start time
// multiply, then output register), with bookkeeping states to take the job
// and open the new candle. a two-entry queue lets the front divide the next
// trade while the back end emits.
// reset (synchronous, active low) clears the candle state and sets the
// timeframe to 60000 ms. a stalled receiver holds the output word and
// backs up into the queue and then the input.
// i_cfg_we writes the timeframe; write only while the block is idle.
module trade_candle_aggregator_core import tca_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [26:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_trade      i_trade,
    output logic        o_valid,
    input  logic        i_ready,
    output t_candle     o_candle
);
    logic [26:0] r_tf;
    logic        n_fv, n_fr, n_qv, n_qr;
    t_job        n_fjob, n_qjob;

    // timeframe register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tf <= TfReset;
        else if (i_cfg_we) r_tf <= i_cfg_wdata;
    end

    tca_front u_front (
        .i_clk, .i_rst_n, .i_tf(r_tf),
        .i_valid, .o_ready, .i_trade,
        .o_valid(n_fv), .i_ready(n_fr), .o_job(n_fjob)
    );

    tca_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(n_fv), .o_ready(n_fr), .i_job(n_fjob),
        .o_valid(n_qv), .i_ready(n_qr), .o_job(n_qjob)
    );

    tca_back u_back (
        .i_clk, .i_rst_n, .i_tf(r_tf),
        .i_valid(n_qv), .o_ready(n_qr), .i_job(n_qjob),
        .o_valid, .i_ready, .o_candle
    );
endmodule

>>> bench/tb_trade_candle_aggregator_core.sv
// testbench for trade_candle_aggregator_core: directed table, then random trades
// predicts every candle word in-bench and checks each output word in order
// depends on tca_pkg and the core rtl
module tb_trade_candle_aggregator_core import tca_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 1000000;
    localparam int unsigned SettleCycles = 150;
    localparam int unsigned RandItems = 380;
    localparam int unsigned NumPhases = 5;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [26:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_trade      i_trade = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_candle     o_candle;

    trade_candle_aggregator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_trade    (i_trade),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_candle   (o_candle)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // candle state mirror
    logic [26:0] tf_reg = TfReset;
    bit          candle_open = 1'b0;
    logic [47:0] open_bucket = '0;
    logic [31:0] c_open = '0, c_high = '0, c_low = '0, c_close = '0;
    logic [47:0] c_buy = '0, c_sell = '0;
    logic [31:0] c_count = '0;

    t_candle     candles_due[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit          steady = 1'b0;

    function automatic logic [47:0] sat_sum48(logic [47:0] a, logic [39:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    function automatic t_candle candle_word(logic [47:0] bkt, logic [47:0] tf,
                                            bit gap);
        t_candle c;
        logic [95:0] prod;
        prod = {48'd0, bkt} * {48'd0, tf};
        c = '0;
        c.start_ms = prod[47:0];
        if (gap) begin
            c.open_price = c_close;
            c.high_price = c_close;
            c.low_price = c_close;
            c.close_price = c_close;
            c.is_gap_fill = 1'b1;
        end else begin
            c.open_price = c_open;
            c.high_price = c_high;
            c.low_price = c_low;
            c.close_price = c_close;
            c.buy_volume = c_buy;
            c.sell_volume = c_sell;
            c.trade_count = c_count;
        end
        return c;
    endfunction

    // fold one trade into the candle state, queue the words it emits
    function automatic int candles_from_trade(t_trade tr);
        logic [47:0] tf;
        logic [47:0] bkt;
        logic [47:0] gaps;
        int n;
        int k;
        t_candle c;
        tf = (tf_reg == 0) ? 48'd1 : {21'd0, tf_reg};
        bkt = tr.timestamp_ms / tf;
        k = 0;
        if (candle_open && bkt == open_bucket) begin
            if (tr.price > c_high) c_high = tr.price;
            if (tr.price < c_low) c_low = tr.price;
            c_close = tr.price;
            if (tr.is_buy) c_buy = sat_sum48(c_buy, tr.volume);
            else c_sell = sat_sum48(c_sell, tr.volume);
            if (c_count != '1) c_count++;
            return 0;
        end
        if (candle_open) begin
            c = candle_word(open_bucket, tf, 1'b0);
            gaps = 0;
            n = 0;
            if (bkt > open_bucket) begin
                gaps = bkt - open_bucket - 1;
                n = (gaps > MaxFill) ? MaxFill : int'(gaps);
            end
            for (int i = 1; i <= n; i++) begin
                candles_due.push_back(c);
                k++;
                c = candle_word(open_bucket + i, tf, 1'b1);
            end
            c.gap_truncated = (gaps > MaxFill);
            c.last_of_run = 1'b1;
            candles_due.push_back(c);
            k++;
        end
        candle_open = 1'b1;
        open_bucket = bkt;
        c_open = tr.price;
        c_high = tr.price;
        c_low = tr.price;
        c_close = tr.price;
        c_buy = tr.is_buy ? {8'd0, tr.volume} : 48'd0;
        c_sell = tr.is_buy ? 48'd0 : {8'd0, tr.volume};
        c_count = 1;
        return k;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // receive side: check each word, then randomize ready
    always @(posedge i_clk) begin
        t_candle w;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end else begin
            if (i_rst_n && o_valid && i_ready) begin
                if (candles_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, o_candle);
                end else begin
                    w = candles_due.pop_front();
                    check_field("start_ms", w.start_ms, o_candle.start_ms);
                    check_field("open_price", w.open_price, o_candle.open_price);
                    check_field("high_price", w.high_price, o_candle.high_price);
                    check_field("low_price", w.low_price, o_candle.low_price);
                    check_field("close_price", w.close_price, o_candle.close_price);
                    check_field("buy_volume", w.buy_volume, o_candle.buy_volume);
                    check_field("sell_volume", w.sell_volume, o_candle.sell_volume);
                    check_field("trade_count", w.trade_count, o_candle.trade_count);
                    check_field("is_gap_fill", w.is_gap_fill, o_candle.is_gap_fill);
                    check_field("gap_truncated", w.gap_truncated, o_candle.gap_truncated);
                    check_field("last_of_run", w.last_of_run, o_candle.last_of_run);
                end
            end
            i_ready <= steady || ($urandom_range(99) >= 34);
        end
    end

    // present one trade word and hold it until accepted
    task automatic send_trade(t_trade tr, output int n);
        while (!steady && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_trade <= tr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        n = candles_from_trade(tr);
    endtask

    // drain all words and let a trade with no output finish
    task automatic drain();
        i_valid <= 1'b0;
        while (candles_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_timeframe(logic [26:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tf_reg = v;
    endtask

    // directed stimulus rows; want_n < 0 leaves the count to the predictor
    typedef struct {
        bit          is_cfg;
        logic [26:0] tf;
        t_trade      tr;
        int          want_n;
    } t_row;

    t_row rows[$];

    function automatic void add_trade(logic [31:0] p, logic [39:0] v, bit b,
                                      logic [47:0] ts, int want_n);
        t_row r;
        r.is_cfg = 1'b0;
        r.tf = '0;
        r.tr.price = p;
        r.tr.volume = v;
        r.tr.is_buy = b;
        r.tr.timestamp_ms = ts;
        r.want_n = want_n;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(logic [26:0] v);
        t_row r;
        r.is_cfg = 1'b1;
        r.tf = v;
        r.tr = '0;
        r.want_n = 0;
        rows.push_back(r);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        int n;
        logic [26:0] phase_tf;
        logic [63:0] tfw;
        logic [47:0] ts;
        logic [31:0] last_price;
        t_trade tr;
        int sel;

        // first trade, extremes, gaps, truncation, time going backward
        add_trade(32'd100, 40'd5, 1'b1, 48'd0, 0);
        add_trade('1, '1, 1'b1, 48'd59999, 0);
        add_trade(32'd0, '1, 1'b0, 48'd1000, 0);
        add_trade(32'd50, 40'd7, 1'b0, 48'd60000, 1);
        add_trade(32'd60, 40'd1, 1'b1, 48'd300000, 4);
        add_trade(32'd70, 40'd2, 1'b0, 48'd6000000, 63);
        add_trade(32'd80, 40'd3, 1'b1, 48'd120000, 1);
        // zero timeframe acts as one
        add_cfg(27'd0);
        add_trade(32'd90, 40'd4, 1'b0, 48'd10, 8);
        add_trade(32'd91, 40'd4, 1'b1, 48'd10, 0);
        add_trade(32'd92, 40'd4, 1'b1, 48'd11, 1);
        // start time wrap after a timeframe change on an open candle
        add_cfg(27'd1);
        add_trade(32'd93, 40'd9, 1'b1, '1, 63);
        add_cfg('1);
        add_trade(32'd94, 40'd9, 1'b0, 48'd0, 1);
        add_trade(32'd95, 40'd9, 1'b0, '1, 63);
        add_cfg(27'd86400000);
        add_trade(32'd96, 40'd1, 1'b1, 48'd0, 1);
        add_trade(32'd97, 40'd1, 1'b0, 48'd86399999, 0);
        add_trade(32'd98, 40'd1, 1'b1, 48'd86400000, 1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                write_timeframe(rows[i].tf);
            end else begin
                send_trade(rows[i].tr, n);
                if (rows[i].want_n >= 0 && n != rows[i].want_n) begin
                    errors++;
                    $display("%0t: row %0d word count, expected %0d, actual %0d",
                             $time, i, rows[i].want_n, n);
                end
            end
        end

        // random phases, each at its own timeframe
        ts = '0;
        last_price = 32'd1000;
        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: phase_tf = TfReset;
                1: phase_tf = 27'd1;
                2: phase_tf = 27'($urandom_range(50, 2));
                3: phase_tf = 27'd86400000;
                default: phase_tf = 27'($urandom);
            endcase
            write_timeframe(phase_tf);
            tfw = (phase_tf == 0) ? 64'd1 : {37'd0, phase_tf};
            ts = 48'(rand64() % 64'h0000_0100_0000_0000);
            for (int i = 0; i < RandItems / NumPhases; i++) begin
                steady = (ph == 1 || ph == 3) && (i >= 20 && i < 50);
                sel = $urandom_range(99);
                // mostly trades inside or just past the open bucket
                if (sel < 60) ts = 48'(ts + rand64() % (tfw / 4 + 1));
                else if (sel < 85) ts = 48'(ts + rand64() % (tfw * 3));
                else if (sel < 90) ts = 48'(ts + rand64() % (tfw * 80));
                else if (sel < 95) ts = 48'(ts - rand64() % (tfw * 4));
                else ts = 48'(rand64());
                sel = $urandom_range(9);
                if (sel < 6) last_price = last_price + $urandom_range(20) - 10;
                else if (sel < 8) last_price = $urandom;
                else last_price = (sel == 8) ? 32'd0 : '1;
                tr.price = last_price;
                sel = $urandom_range(9);
                tr.volume = (sel == 0) ? '1 : (sel < 4) ? 40'(rand64()) :
                            40'($urandom_range(1000));
                tr.is_buy = 1'($urandom_range(1));
                tr.timestamp_ms = ts;
                send_trade(tr, n);
            end
            steady = 1'b0;
        end

        drain();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
